FILE: rtl/tdbl_pkg.sv
// Package for the tree distance binary lifting unit.
// Holds sizes, command codes, sequencer states and the structs between modules.
// No dependencies.
package tdbl_pkg;

  localparam int NODE_W      = 15;
  localparam int MAX_NODES   = 2 ** NODE_W;
  localparam int DEPTH_W     = NODE_W;
  localparam int LIFT_LEVELS = 16;
  localparam int LVL_W       = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int ANC_AW      = LVL_W + NODE_W;
  localparam int DIST_W      = 16;
  localparam int SUM_W       = DIST_W + 2;
  localparam int TOTAL_W     = 32;
  localparam int IN_W        = 48;
  localparam int OUT_W       = DIST_W + TOTAL_W;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [LVL_W-1:0]   lvl_t;
  typedef logic [SUM_W-1:0]   sum_t;

  localparam depth_t DEPTH_MAX = {DEPTH_W{1'b1}};
  localparam lvl_t   LAST_LVL  = lvl_t'(LIFT_LEVELS - 1);
  localparam node_t  LAST_NODE = node_t'(MAX_NODES - 1);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_LD_LVL,
    ST_Q_RDA,
    ST_Q_RDB,
    ST_Q_SWAP,
    ST_Q_EQ,
    ST_P1_ANC,
    ST_P1_DEP,
    ST_P1_CMP,
    ST_P2_RA,
    ST_P2_RB,
    ST_P2_CMP,
    ST_FINAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  cmd;
    node_t node;
    node_t other;
  } core_req_t;

  typedef struct packed {
    logic              ready;
    logic              res_valid;
    logic [DIST_W-1:0] distance;
  } core_stat_t;

  typedef struct packed {
    node_t cmp_a;
    node_t cmp_b;
    sum_t  add_a;
    sum_t  add_b;
  } alu_in_t;

  typedef struct packed {
    logic lt;
    logic eq;
    sum_t add_y;
  } alu_out_t;

endpackage

FILE: rtl/tdbl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// A read of the address being written in the same cycle returns the new data.
// No dependencies.
module tdbl_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= (we && waddr == raddr) ? wdata : mem[raddr];
  end

endmodule

FILE: rtl/tdbl_alu.sv
// Shared compare and add unit used by the compare and add steps of the sequencer.
// Depends on tdbl_pkg.
module tdbl_alu
  import tdbl_pkg::*;
(
  input  alu_in_t  alu_in,
  output alu_out_t alu_out
);

  assign alu_out.lt    = alu_in.cmp_a < alu_in.cmp_b;
  assign alu_out.eq    = alu_in.cmp_a == alu_in.cmp_b;
  assign alu_out.add_y = alu_in.add_a + alu_in.add_b;

endmodule

FILE: rtl/tdbl_core.sv
// Sequencer with the depth store and the ancestor table of the binary lifting unit.
// Depends on tdbl_pkg, tdbl_ram and tdbl_alu.
module tdbl_core
  import tdbl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  core_req_t  req,
  input  logic       res_ready,
  output core_stat_t stat
);

  state_t state, state_next;
  node_t  clr_cnt;
  lvl_t   lvl;
  node_t  node_a;
  node_t  node_b;
  node_t  node_x;
  depth_t depth_a;
  depth_t depth_b;
  sum_t   sum;
  logic   anc_rz;

  logic              depth_we;
  node_t             depth_waddr;
  depth_t            depth_wdata;
  node_t             depth_raddr;
  depth_t            depth_rdata;
  logic              anc_we;
  logic [ANC_AW-1:0] anc_waddr;
  node_t             anc_wdata;
  logic [ANC_AW-1:0] anc_raddr;
  node_t             anc_rdata;
  node_t             anc_val;
  alu_in_t           alu_in;
  alu_out_t          alu_out;

  tdbl_ram #(.AW(NODE_W), .DW(DEPTH_W)) u_depth (
    .clk   (clk),
    .we    (depth_we),
    .waddr (depth_waddr),
    .wdata (depth_wdata),
    .raddr (depth_raddr),
    .rdata (depth_rdata)
  );

  tdbl_ram #(.AW(ANC_AW), .DW(NODE_W)) u_anc (
    .clk   (clk),
    .we    (anc_we),
    .waddr (anc_waddr),
    .wdata (anc_wdata),
    .raddr (anc_raddr),
    .rdata (anc_rdata)
  );

  tdbl_alu u_alu (
    .alu_in  (alu_in),
    .alu_out (alu_out)
  );

  // Entries of node zero are never written and always read as zero.
  assign anc_val = anc_rz ? '0 : anc_rdata;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == LAST_NODE) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          if (req.cmd == CMD_QUERY) begin
            state_next = ST_Q_RDA;
          end else if (req.node != '0) begin
            state_next = ST_LD_RD;
          end
        end
      end
      ST_LD_RD:  state_next = ST_LD_WR;
      ST_LD_WR:  state_next = (LIFT_LEVELS > 1) ? ST_LD_LVL : ST_IDLE;
      ST_LD_LVL: begin
        if (lvl == LAST_LVL) state_next = ST_IDLE;
      end
      ST_Q_RDA:  state_next = ST_Q_RDB;
      ST_Q_RDB:  state_next = ST_Q_SWAP;
      ST_Q_SWAP: state_next = ST_Q_EQ;
      ST_Q_EQ:   state_next = alu_out.eq ? ST_DONE : ST_P1_ANC;
      ST_P1_ANC: state_next = ST_P1_DEP;
      ST_P1_DEP: state_next = ST_P1_CMP;
      ST_P1_CMP: state_next = (lvl == '0) ? ST_P2_RA : ST_P1_ANC;
      ST_P2_RA:  state_next = ST_P2_RB;
      ST_P2_RB:  state_next = ST_P2_CMP;
      ST_P2_CMP: state_next = (lvl == '0) ? ST_FINAL : ST_P2_RA;
      ST_FINAL:  state_next = ST_DONE;
      ST_DONE: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    depth_we     = 1'b0;
    depth_waddr  = node_a;
    depth_wdata  = '0;
    depth_raddr  = node_a;
    anc_we       = 1'b0;
    anc_waddr    = {lvl, node_a};
    anc_wdata    = anc_val;
    anc_raddr    = {lvl, node_a};
    alu_in       = '0;
    case (state)
      ST_CLEAR: begin
        depth_we    = 1'b1;
        depth_waddr = clr_cnt;
      end
      ST_LD_RD: begin
        depth_raddr = node_b;
      end
      ST_LD_WR: begin
        alu_in.add_a = sum_t'(depth_rdata);
        alu_in.add_b = sum_t'(1);
        depth_we     = 1'b1;
        depth_wdata  = alu_out.add_y[DEPTH_W] ? DEPTH_MAX : alu_out.add_y[DEPTH_W-1:0];
        anc_we       = 1'b1;
        anc_waddr    = {lvl_t'(0), node_a};
        anc_wdata    = node_b;
        anc_raddr    = {lvl_t'(0), node_b};
      end
      ST_LD_LVL: begin
        anc_we    = 1'b1;
        anc_waddr = {lvl, node_a};
        anc_wdata = anc_val;
        anc_raddr = {lvl, anc_val};
      end
      ST_Q_RDA: begin
        depth_raddr = node_a;
      end
      ST_Q_RDB: begin
        depth_raddr = node_b;
      end
      ST_Q_SWAP: begin
        alu_in.cmp_a = depth_a;
        alu_in.cmp_b = depth_rdata;
      end
      ST_Q_EQ: begin
        alu_in.cmp_a = node_a;
        alu_in.cmp_b = node_b;
      end
      ST_P1_ANC: begin
        anc_raddr = {lvl, node_a};
      end
      ST_P1_DEP: begin
        depth_raddr = anc_val;
      end
      ST_P1_CMP: begin
        alu_in.cmp_a = depth_rdata;
        alu_in.cmp_b = depth_b;
        alu_in.add_a = sum;
        alu_in.add_b = sum_t'(1) << lvl;
      end
      ST_P2_RA: begin
        anc_raddr = {lvl, node_a};
      end
      ST_P2_RB: begin
        anc_raddr = {lvl, node_b};
      end
      ST_P2_CMP: begin
        alu_in.cmp_a = node_x;
        alu_in.cmp_b = anc_val;
        alu_in.add_a = sum;
        alu_in.add_b = sum_t'(2) << lvl;
      end
      ST_FINAL: begin
        alu_in.cmp_a = node_a;
        alu_in.cmp_b = node_b;
        alu_in.add_a = sum;
        alu_in.add_b = sum_t'(2);
      end
      default: begin
      end
    endcase
  end

  assign stat.ready     = (state == ST_IDLE);
  assign stat.res_valid = (state == ST_DONE);
  assign stat.distance  = (sum > sum_t'({DIST_W{1'b1}})) ? {DIST_W{1'b1}} : sum[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + node_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    anc_rz <= (anc_raddr[NODE_W-1:0] == '0);
    case (state)
      ST_IDLE: begin
        node_a <= req.node;
        node_b <= req.other;
        sum    <= '0;
        lvl    <= (req.cmd == CMD_QUERY) ? LAST_LVL : lvl_t'(0);
      end
      ST_LD_WR: begin
        lvl <= lvl_t'(1);
      end
      ST_LD_LVL: begin
        lvl <= lvl + lvl_t'(1);
      end
      ST_Q_RDB: begin
        depth_a <= depth_rdata;
      end
      ST_Q_SWAP: begin
        if (alu_out.lt) begin
          node_a  <= node_b;
          node_b  <= node_a;
          depth_b <= depth_a;
        end else begin
          depth_b <= depth_rdata;
        end
      end
      ST_P1_DEP: begin
        node_x <= anc_val;
      end
      ST_P1_CMP: begin
        if (!alu_out.lt) begin
          node_a <= node_x;
          sum    <= alu_out.add_y;
        end
        lvl <= (lvl == '0) ? LAST_LVL : lvl - lvl_t'(1);
      end
      ST_P2_RB: begin
        node_x <= anc_val;
      end
      ST_P2_CMP: begin
        if (!alu_out.eq) begin
          node_a <= node_x;
          node_b <= anc_val;
          sum    <= alu_out.add_y;
        end
        lvl <= lvl - lvl_t'(1);
      end
      ST_FINAL: begin
        if (!alu_out.eq) sum <= alu_out.add_y;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_load_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LD_LVL && lvl == LAST_LVL) |=> state == ST_IDLE)
    else $error("load sequence did not end after the last level");

  a_lvl_down: assert property (@(posedge clk) disable iff (rst)
    (state == ST_P1_CMP && lvl != '0) |=> lvl == $past(lvl) - lvl_t'(1))
    else $error("lifting level did not step down");

  a_no_sentinel_write: assert property (@(posedge clk) disable iff (rst)
    anc_we |-> anc_waddr[NODE_W-1:0] != '0)
    else $error("ancestor entry of node zero written");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !anc_we && !stat.res_valid)
    else $error("activity during the clearing pass");
`endif

endmodule

FILE: rtl/tree_distance_binary_lifting_unit.sv
// Top level of the tree distance binary lifting unit: stream ports, query origin
// tracking, saturating walk total and the result register.
// Depends on tdbl_pkg and tdbl_core.
//
// After reset the depth store is cleared one entry a cycle, with s_tready low. A
// load item is accepted, then makes one depth read, the level-zero write, then one
// dependent ancestor table read and write per remaining level; a load of node zero
// is dropped. A query item reads and orders the two depths and compares the two
// nodes, then climbs the deeper node per level (ancestor read, depth read,
// compare), then climbs both nodes together per level (two ancestor reads,
// compare), and finishes; a query of a node against itself ends after the node
// compare. The single read port of each memory sets this order of steps. A
// finished result waits in an output register while the next item is taken.
module tree_distance_binary_lifting_unit
  import tdbl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // node, parent, peer, zero padding
  input  logic             s_tuser,   // cmd
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // distance, walk_total
);

  logic               seen;
  node_t              last_q;
  logic [TOTAL_W-1:0] total;
  logic [DIST_W-1:0]  out_dist;
  logic [TOTAL_W-1:0] out_total;
  logic [TOTAL_W:0]   total_sum;
  logic [TOTAL_W-1:0] total_next;
  logic               s_accept;
  logic               res_ready;
  logic               out_load;
  node_t              in_node;
  node_t              in_parent;
  node_t              in_peer;
  core_req_t          req;
  core_stat_t         stat;

  assign in_node   = s_tdata[NODE_W-1:0];
  assign in_parent = s_tdata[2*NODE_W-1:NODE_W];
  assign in_peer   = s_tdata[3*NODE_W-1:2*NODE_W];

  assign s_tready = stat.ready;
  assign s_accept = s_tvalid && s_tready;

  assign req.cmd   = s_tuser;
  assign req.node  = in_node;
  assign req.other = (s_tuser == CMD_LOAD) ? in_parent : (seen ? last_q : in_peer);

  tdbl_core u_core (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_accept),
    .req       (req),
    .res_ready (res_ready),
    .stat      (stat)
  );

  assign res_ready  = !m_tvalid || m_tready;
  assign out_load   = stat.res_valid && res_ready;
  assign total_sum  = {1'b0, total} + (TOTAL_W + 1)'(stat.distance);
  assign total_next = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      seen     <= 1'b0;
      last_q   <= node_t'(1);
      total    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_accept && s_tuser == CMD_QUERY) begin
        seen   <= 1'b1;
        last_q <= in_node;
      end
      if (out_load) begin
        total    <= total_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_dist  <= stat.distance;
      out_total <= total_next;
    end
  end

  assign m_tdata = {out_total, out_dist};

`ifndef SYNTHESIS
  a_total_grows: assert property (@(posedge clk) disable iff (rst)
    out_load |=> total >= $past(total))
    else $error("walk total decreased");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (s_accept && s_tuser == CMD_QUERY) |=> !s_tready)
    else $error("query item did not occupy the core");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("pending result overwritten");
`endif

endmodule

FILE: tb/tb_top.sv
// Testbench for tree_distance_binary_lifting_unit: builds trees with load items, asks path
// lengths with query items and checks every result item against a binary-lifting predictor.
// Depends on tdbl_pkg and the unit's RTL.
module tb_top
  import tdbl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT  = 3_000_000;
  localparam int     HOLD_CYCLES  = 2500;
  localparam int     DRAIN_CYCLES = 150;
  localparam int     PRINT_CAP    = 40;
  localparam int     RELOAD_COUNT = 40;

  typedef struct {
    logic [DIST_W-1:0]  distance;
    logic [TOTAL_W-1:0] walk_total;
  } walk_result_t;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic             s_tuser  = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  bit [DEPTH_W-1:0] depth_mem [MAX_NODES];
  bit [NODE_W-1:0]  anc_mem [LIFT_LEVELS][MAX_NODES];
  node_t            last_node    = node_t'(1);
  bit               walk_started = 1'b0;
  bit [TOTAL_W-1:0] walk_sum     = '0;
  walk_result_t     walk_results_due[$];

  node_t  loaded_pool[$];
  bit     is_loaded [MAX_NODES];
  int     send_idle_pct = 27;
  int     recv_idle_pct = 72;
  bit     hold_req      = 1'b0;
  bit     hold_rx       = 1'b0;
  int     errors        = 0;
  int     n_loads       = 0;
  int     n_dropped     = 0;
  int     n_queries     = 0;
  int     n_checked     = 0;
  int     deepest       = 0;
  int     stall_cycles  = 0;
  longint cycles        = 0;

  tree_distance_binary_lifting_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  function automatic void load_into_tree(node_t v, node_t p);
    int unsigned d;
    if (v == '0) begin
      n_dropped++;
      return;
    end
    n_loads++;
    d = depth_mem[p] + 1;
    depth_mem[v] = (d > DEPTH_MAX) ? DEPTH_MAX : d[DEPTH_W-1:0];
    if (int'(depth_mem[v]) > deepest) deepest = int'(depth_mem[v]);
    anc_mem[0][v] = p;
    for (int j = 1; j < LIFT_LEVELS; j++) begin
      anc_mem[j][v] = anc_mem[j-1][anc_mem[j-1][v]];
    end
  endfunction

  function automatic int unsigned path_edges(node_t a, node_t b);
    node_t       t;
    node_t       xa;
    node_t       xb;
    int unsigned sum;
    sum = 0;
    if (depth_mem[a] < depth_mem[b]) begin
      t = a;
      a = b;
      b = t;
    end
    if (a == b) return 0;
    for (int lvl = LIFT_LEVELS - 1; lvl >= 0; lvl--) begin
      xa = anc_mem[lvl][a];
      if (depth_mem[xa] >= depth_mem[b]) begin
        a = xa;
        sum += 1 << lvl;
      end
    end
    for (int lvl = LIFT_LEVELS - 1; lvl >= 0; lvl--) begin
      xa = anc_mem[lvl][a];
      xb = anc_mem[lvl][b];
      if (xa != xb) begin
        a = xa;
        b = xb;
        sum += 2 << lvl;
      end
    end
    if (a != b) sum += 2;
    return sum;
  endfunction

  function automatic void predict_item(logic cmd, node_t node, node_t parent, node_t peer);
    node_t        from;
    int unsigned  edges;
    walk_result_t r;
    if (cmd == CMD_LOAD) begin
      load_into_tree(node, parent);
      return;
    end
    n_queries++;
    from = walk_started ? last_node : peer;
    edges = path_edges(node, from);
    if (edges > 32'h0000_FFFF) edges = 32'h0000_FFFF;
    if (walk_sum > 32'hFFFF_FFFF - edges) walk_sum = '1;
    else walk_sum += edges;
    last_node    = node;
    walk_started = 1'b1;
    r.distance   = edges[DIST_W-1:0];
    r.walk_total = walk_sum;
    walk_results_due.insert(walk_results_due.size(), r);
  endfunction

  function automatic node_t pick_loaded();
    int n;
    n = loaded_pool.size();
    if ($urandom_range(0, 1) == 1) begin
      return loaded_pool[n - 1 - $urandom_range(0, (n < 8) ? n - 1 : 7)];
    end
    return loaded_pool[$urandom_range(0, n - 1)];
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= PRINT_CAP) $display("ERROR at cycle %0d: %s", cycles, what);
  endtask

  task automatic send_item(logic cmd, node_t node, node_t parent, node_t peer);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= IN_W'({peer, parent, node});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_item(cmd, node, parent, peer);
  endtask

  task automatic send_load(node_t v, node_t p);
    if (v != '0 && !is_loaded[v]) begin
      is_loaded[v] = 1'b1;
      loaded_pool.insert(loaded_pool.size(), v);
    end
    send_item(CMD_LOAD, v, p, node_t'($urandom));
  endtask

  task automatic send_query(node_t v, node_t peer);
    send_item(CMD_QUERY, v, node_t'($urandom), peer);
  endtask

  task automatic run_directed_tree();
    send_load(node_t'(0), node_t'(32767));
    send_load(node_t'(1), node_t'(0));
    send_load(node_t'(32767), node_t'(1));
    send_load(node_t'(2), node_t'(32767));
    send_load(node_t'(3), node_t'(2));
    send_load(node_t'(16384), node_t'(1));
    send_load(node_t'(21845), node_t'(16384));
    send_load(node_t'(10922), node_t'(21845));
    send_query(node_t'(3), node_t'(16384));
    send_query(node_t'(3), node_t'(32767));
    send_query(node_t'(32767), node_t'(1));
    send_query(node_t'(1), node_t'(0));
    send_query(node_t'(10922), node_t'(32767));
    send_query(node_t'(21845), node_t'(1));
    send_load(node_t'(4), node_t'(3));
    send_query(node_t'(4), node_t'(0));
    send_query(node_t'(16384), node_t'(32767));
    send_load(node_t'(0), node_t'(0));
    send_load(node_t'(21845), node_t'(4));
    send_query(node_t'(21845), node_t'(1));
    send_query(node_t'(10922), node_t'(1));
    send_query(node_t'(2), node_t'(1));
  endtask

  // Two nodes reloaded under each other push the stored depth up by one per item.
  task automatic run_cyclic_reload();
    send_load(node_t'(32766), node_t'(0));
    for (int i = 0; i < RELOAD_COUNT; i++) begin
      if (i % 2 == 0) send_load(node_t'(32765), node_t'(32766));
      else send_load(node_t'(32766), node_t'(32765));
    end
    send_query(node_t'(32766), node_t'($urandom));
    send_query(node_t'(32765), node_t'($urandom));
    send_query(node_t'(3), node_t'($urandom));
    send_query(node_t'(32766), node_t'($urandom));
    send_load(node_t'(32766), node_t'(0));
    send_load(node_t'(32765), node_t'(32766));
    send_query(node_t'(32765), node_t'($urandom));
  endtask

  task automatic run_random_walk(int items, int s_pct, int r_pct);
    int    done;
    int    roll;
    node_t v;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    done = 0;
    while (done < items) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        send_load(node_t'(0), node_t'($urandom));
      end else begin
        if (roll < 45) begin
          v = ($urandom_range(0, 9) < 7) ? node_t'($urandom_range(1, MAX_NODES - 1))
                                        : pick_loaded();
          send_load(v, ($urandom_range(0, 9) == 0) ? node_t'(0) : pick_loaded());
        end else if (roll < 52) begin
          send_query(last_node, node_t'($urandom));
        end else begin
          send_query(pick_loaded(), node_t'($urandom));
        end
        done++;
      end
    end
  endtask

  task automatic run_output_stall(int items);
    hold_req = 1'b1;
    run_random_walk(items, 0, 0);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tree_distance_binary_lifting_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_rx && s_tvalid && !s_tready) stall_cycles++;
    if (hold_rx) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  always @(posedge clk) begin
    walk_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_checked++;
      if (walk_results_due.size() == 0) begin
        report_mismatch("result item with no query waiting");
      end else begin
        want = walk_results_due.pop_front();
        if (m_tdata[DIST_W-1:0] !== want.distance)
          report_mismatch($sformatf("distance %0d, expected %0d",
                                    m_tdata[DIST_W-1:0], want.distance));
        if (m_tdata[OUT_W-1:DIST_W] !== want.walk_total)
          report_mismatch($sformatf("walk_total %0d, expected %0d",
                                    m_tdata[OUT_W-1:DIST_W], want.walk_total));
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    run_directed_tree();
    run_cyclic_reload();
    run_random_walk(310, 27, 72);
    run_random_walk(310, 72, 27);
    run_output_stall(310);
    s_tvalid <= 1'b0;
    while (walk_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d loads, %0d dropped node-zero loads and %0d distance queries.",
             n_loads, n_dropped, n_queries);
    $display("Checked %0d results; deepest depth %0d; input stalled %0d cycles; %0d errors.",
             n_checked, deepest, stall_cycles, errors);
    if (errors == 0) begin
      $display("tree_distance_binary_lifting_unit verification clean");
    end else begin
      $display("tree_distance_binary_lifting_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/tdbl_pkg.sv
rtl/tdbl_ram.sv
rtl/tdbl_alu.sv
rtl/tdbl_core.sv
rtl/tree_distance_binary_lifting_unit.sv
tb/tb_top.sv
